/* hdl/swa_pkg.sv */
package swa_pkg;

    localparam int DEF_WINDOW      = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int SAMPLE_W        = 16;
    localparam int AVERAGE_W       = 16;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

endpackage

/* hdl/sliding_window_average_unit.sv */
// Moving average over a ring of WINDOW unsigned samples.
// Input channel: i_valid / o_ready with i_sample. Output channel: o_valid /
// i_ready with o_average and o_window_full.
// Each accepted sample overwrites the oldest ring entry; the result is the
// truncated mean of the stored samples, new one included. o_window_full is
// set once the ring holds WINDOW samples.
// The sample is accepted, the ring and total are updated, then the restoring
// divider produces one quotient bit per cycle, SW + clog2(WINDOW) bits in all,
// SW = min(SAMPLE_BITS, 16), before the result is presented. One item is in
// flight at a time, so a new sample is taken only after the receiver has
// taken the result.
// A stalled receiver holds the result on the outputs; o_ready stays low
// until the result is taken.
// Reset clears pointer, total and fill count; the sample memory is not
// cleared, as an entry's old value is only used after it has been written.
module sliding_window_average_unit #(
    parameter int WINDOW      = swa_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [swa_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [swa_pkg::AVERAGE_W-1:0]  o_average,
    output logic                           o_window_full
);

    swa_pkg::t_dp_cmd    cmd;
    swa_pkg::t_dp_status status;

    swa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    swa_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_sample),
        .o_average     (o_average),
        .o_window_full (o_window_full)
    );

endmodule

/* hdl/swa_ctrl.sv */
module swa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    input  swa_pkg::t_dp_status i_status,
    output swa_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.update   = 1'b0;
        o_cmd.div_step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output sides open together");

    a_accept_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.update)
        else $error("accepted item not followed by update");

    a_div_leads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_status.div_last) |=> o_valid)
        else $error("divider finished without presenting result");

endmodule

/* hdl/swa_dp.sv */
module swa_dp #(
    parameter int WINDOW      = swa_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swa_pkg::t_dp_cmd               i_cmd,
    output swa_pkg::t_dp_status            o_status,
    input  logic [swa_pkg::SAMPLE_W-1:0]   i_sample,
    output logic [swa_pkg::AVERAGE_W-1:0]  o_average,
    output logic                           o_window_full
);

    localparam int SW  = (SAMPLE_BITS < swa_pkg::SAMPLE_W) ? SAMPLE_BITS : swa_pkg::SAMPLE_W;
    localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int TW  = SW + PW;
    localparam int SCW = $clog2(TW);

    logic [SW-1:0]  r_mem [WINDOW];
    logic [SW-1:0]  r_sample;
    logic [SW-1:0]  r_oldest;
    logic [PW-1:0]  r_wptr;
    logic [TW-1:0]  r_total;
    logic [CW-1:0]  r_count;
    logic           r_full;
    logic [TW-1:0]  r_quo;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_dvs;
    logic [SCW-1:0] r_step;

    logic           full_before;
    logic [TW-1:0]  n_total;
    logic [CW-1:0]  n_count;
    logic [PW-1:0]  n_wptr;
    logic [CW:0]    rem_shift;
    logic           rem_ge;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_oldest <= r_mem[r_wptr];
        end
        if (i_cmd.update) begin
            r_mem[r_wptr] <= r_sample;
        end
    end

    assign full_before = (r_count == CW'(WINDOW));
    assign n_total     = r_total + TW'(r_sample) - (full_before ? TW'(r_oldest) : '0);
    assign n_count     = full_before ? r_count : r_count + CW'(1);
    assign n_wptr      = (r_wptr == PW'(WINDOW - 1)) ? '0 : r_wptr + PW'(1);

    assign rem_shift = {r_rem, r_quo[TW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_total <= '0;
            r_count <= '0;
            r_full  <= 1'b0;
            r_step  <= '0;
        end else begin
            if (i_cmd.update) begin
                r_wptr  <= n_wptr;
                r_total <= n_total;
                r_count <= n_count;
                r_full  <= (n_count == CW'(WINDOW));
                r_step  <= SCW'(TW - 1);
            end else if (i_cmd.div_step) begin
                r_step <= r_step - SCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= SW'(i_sample);
        end
        if (i_cmd.update) begin
            r_quo <= n_total;
            r_rem <= '0;
            r_dvs <= n_count;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[TW-2:0], rem_ge};
            r_rem <= rem_ge ? CW'(rem_shift - {1'b0, r_dvs}) : CW'(rem_shift);
        end
    end

    assign o_status.div_last = (r_step == '0);
    assign o_average         = swa_pkg::AVERAGE_W'(r_quo);
    assign o_window_full     = r_full;

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= PW'(WINDOW - 1))
        else $error("write pointer out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW))
        else $error("fill count beyond window");

    a_fill_tracks_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CW'(WINDOW)) |-> (CW'(r_wptr) == r_count))
        else $error("pointer and fill count disagree while filling");

endmodule
